// File: src/imwm_pkg.sv
// imwm_pkg: shared types and constants of the ichimoku window midpoint block
// used by the configuration channel interface, the window scan unit and the top level
`default_nettype none

package imwm_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int WIN_W      = 7;
  localparam int SHIFT_W    = 6;
  localparam int BARS_W     = 7;

  localparam logic [BARS_W-1:0]     BARS_MAX          = 7'd127;
  localparam logic [WIN_W-1:0]      SHORT_WINDOW_RST  = 7'd9;
  localparam logic [WIN_W-1:0]      MEDIUM_WINDOW_RST = 7'd26;
  localparam logic [WIN_W-1:0]      LONG_WINDOW_RST   = 7'd52;
  localparam logic [SHIFT_W-1:0]    SPAN_SHIFT_RST    = 6'd26;
  localparam logic [CFG_DATA_W-1:0] LOW_CEILING_RST   = 32'd2560000000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SHORT_WINDOW  = 3'd0,
    CFG_MEDIUM_WINDOW = 3'd1,
    CFG_LONG_WINDOW   = 3'd2,
    CFG_SPAN_SHIFT    = 3'd3,
    CFG_LOW_CEILING   = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic              start;
    logic [BARS_W-1:0] bars;
    logic [WIN_W-1:0]  win_short;
    logic [WIN_W-1:0]  win_medium;
    logic [WIN_W-1:0]  win_long;
  } scan_req_t;

endpackage

`default_nettype wire

// File: src/imwm_in_if.sv
// imwm_in_if: price bar item channel (valid/ready)
// widths follow PRICE_WIDTH; no package dependency
`default_nettype none

interface imwm_in_if #(
  parameter int PRICE_WIDTH = 32
);
  logic                   valid;
  logic                   ready;
  logic [PRICE_WIDTH-1:0] bar_high;
  logic [PRICE_WIDTH-1:0] bar_low;
  logic                   series_start;

  modport source (output valid, bar_high, bar_low, series_start, input ready);
  modport sink   (input valid, bar_high, bar_low, series_start, output ready);
endinterface

`default_nettype wire

// File: src/imwm_out_if.sv
// imwm_out_if: result item channel (valid/ready)
// widths follow PRICE_WIDTH; no package dependency
`default_nettype none

interface imwm_out_if #(
  parameter int PRICE_WIDTH = 32
);
  logic                   valid;
  logic                   ready;
  logic [PRICE_WIDTH:0]   base_line;
  logic [PRICE_WIDTH:0]   conversion_line;
  logic [PRICE_WIDTH+1:0] leading_span_a;
  logic [PRICE_WIDTH:0]   leading_span_b;

  modport source (output valid, base_line, conversion_line, leading_span_a,
                  leading_span_b, input ready);
  modport sink   (input valid, base_line, conversion_line, leading_span_a,
                  leading_span_b, output ready);
endinterface

`default_nettype wire

// File: src/imwm_cfg_if.sv
// imwm_cfg_if: configuration write channel (valid/ready, index and data)
// depends on imwm_pkg for field widths
`default_nettype none

interface imwm_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [imwm_pkg::CFG_IDX_W-1:0]   reg_index;
  logic [imwm_pkg::CFG_DATA_W-1:0]  wr_data;

  modport source (output valid, reg_index, wr_data, input ready);
  modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

`default_nettype wire

// File: src/imwm_scan.sv
// imwm_scan: bar history memories and one max/min compare unit that walks
// back from the newest bar, one entry a cycle; depends on imwm_pkg
`default_nettype none

module imwm_scan #(
  parameter int HISTORY_DEPTH = 64,
  parameter int PRICE_WIDTH   = 32
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire imwm_pkg::scan_req_t              req,
  input  wire logic [$clog2(HISTORY_DEPTH)-1:0] ptr,
  input  wire logic [PRICE_WIDTH-1:0]           ceiling,
  input  wire logic                             wr_en,
  input  wire logic [$clog2(HISTORY_DEPTH)-1:0] wr_addr,
  input  wire logic [PRICE_WIDTH-1:0]           wr_high,
  input  wire logic [PRICE_WIDTH-1:0]           wr_low,
  output logic                                  done,
  output logic [PRICE_WIDTH:0]                  conv_sum,
  output logic [PRICE_WIDTH:0]                  base_sum,
  output logic [PRICE_WIDTH:0]                  long_sum
);

  localparam int AW   = $clog2(HISTORY_DEPTH);
  localparam int CNTW = $clog2(HISTORY_DEPTH + 1);

  function automatic logic [CNTW-1:0] eff_window(input logic [imwm_pkg::WIN_W-1:0] w);
    logic [31:0] t;
    begin
      t = 32'(w);
      if (t == 32'd0) begin
        t = 32'd1;
      end else if (t > 32'(HISTORY_DEPTH)) begin
        t = 32'(HISTORY_DEPTH);
      end
      return t[CNTW-1:0];
    end
  endfunction

  logic [PRICE_WIDTH-1:0] hist_high [HISTORY_DEPTH];
  logic [PRICE_WIDTH-1:0] hist_low  [HISTORY_DEPTH];

  logic [PRICE_WIDTH-1:0] hq_r, lq_r;
  logic [AW-1:0]          ra_r;
  logic [CNTW-1:0]        ki_r, rk_r;
  logic                   busy_r, rv_r, done_r;
  logic [PRICE_WIDTH-1:0] hi_r, lo_r;
  logic [PRICE_WIDTH:0]   sum_s_r, sum_m_r, sum_l_r;
  logic [imwm_pkg::BARS_W-1:0] j_r;
  logic [imwm_pkg::WIN_W-1:0]  win_s_r, win_m_r, win_l_r;

  logic [CNTW-1:0]        ws, wm, wl, wmax;
  logic                   issue;
  logic [PRICE_WIDTH-1:0] nh, nl;
  logic [PRICE_WIDTH:0]   nsum;

  assign ws   = eff_window(win_s_r);
  assign wm   = eff_window(win_m_r);
  assign wl   = eff_window(win_l_r);
  assign wmax = (ws > wm) ? ((ws > wl) ? ws : wl) : ((wm > wl) ? wm : wl);

  assign issue = busy_r && (ki_r != wmax) && !req.start;
  assign nh    = (hq_r > hi_r) ? hq_r : hi_r;
  assign nl    = (lq_r < lo_r) ? lq_r : lo_r;
  assign nsum  = {1'b0, nh} + {1'b0, nl};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      hist_high[wr_addr] <= wr_high;
      hist_low[wr_addr]  <= wr_low;
    end
    hq_r <= hist_high[ra_r];
    lq_r <= hist_low[ra_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      rv_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      rv_r   <= issue;
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (rv_r && rk_r == wmax - 1'b1) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rk_r <= ki_r;
    if (req.start) begin
      ra_r    <= ptr;
      ki_r    <= '0;
      hi_r    <= '0;
      lo_r    <= ceiling;
      j_r     <= req.bars;
      win_s_r <= req.win_short;
      win_m_r <= req.win_medium;
      win_l_r <= req.win_long;
    end else begin
      if (issue) begin
        ra_r <= (ra_r == '0) ? AW'(HISTORY_DEPTH - 1) : ra_r - 1'b1;
        ki_r <= ki_r + 1'b1;
      end
      if (rv_r) begin
        hi_r <= nh;
        lo_r <= nl;
        if (rk_r == ws - 1'b1) begin
          sum_s_r <= nsum;
        end
        if (rk_r == wm - 1'b1) begin
          sum_m_r <= nsum;
        end
        if (rk_r == wl - 1'b1) begin
          sum_l_r <= nsum;
        end
      end
    end
  end

  // a line stays zero until the bar index in the series (zero for its first bar) exceeds its window
  assign conv_sum = (32'(j_r) > 32'(ws)) ? sum_s_r : '0;
  assign base_sum = (32'(j_r) > 32'(wm)) ? sum_m_r : '0;
  assign long_sum = (32'(j_r) > 32'(wl)) ? sum_l_r : '0;
  assign done     = done_r;

endmodule

`default_nettype wire

// File: src/ichimoku_window_midpoints.sv
// ichimoku_window_midpoints: conversion line, base line and delayed leading
// spans over a stream of price bars; uses imwm_pkg, the imwm_*_if channels
// and imwm_scan
//
// usage:
//   in_chan  takes one bar item (high, low, series_start) while ready is high
//   out_chan gives one result item for every bar of a series but the first
//   cfg_chan writes the window, shift and ceiling registers; always ready,
//     write only while no item is in flight
// flow:
//   an accepted item is scanned, its delayed spans are read, then its result
//   is loaded into the output register; the single compare unit walks the
//   history memory one entry a cycle, back over the largest of the three
//   windows clamped to HISTORY_DEPTH. the first bar of a series gives no result
//   in_chan is not ready while an item is being worked on, so the next item
//   is taken only after the result of the last is loaded
// reset: registers take their default values, history and delays are empty
// stall: a finished result sits in the output register until taken; the
//   next item may be accepted meanwhile, but its own result waits for it
`default_nettype none

module ichimoku_window_midpoints #(
  parameter int HISTORY_DEPTH = 64,
  parameter int DELAY_DEPTH   = 64,
  parameter int PRICE_WIDTH   = 32
) (
  input wire logic clk,
  input wire logic rst_n,
  imwm_in_if.sink    in_chan,
  imwm_out_if.source out_chan,
  imwm_cfg_if.sink   cfg_chan
);

  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam int DW = $clog2(DELAY_DEPTH);
  localparam int PW = PRICE_WIDTH;
  localparam int XW = imwm_pkg::CFG_DATA_W + PW;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_RD, S_OUT} state_t;

  state_t state_r;

  logic [imwm_pkg::WIN_W-1:0]      win_s_r, win_m_r, win_l_r;
  logic [imwm_pkg::SHIFT_W-1:0]    shift_r;
  logic [imwm_pkg::CFG_DATA_W-1:0] ceil_r;

  logic [imwm_pkg::BARS_W-1:0] bars_r;
  logic [AW-1:0]               ptr_r;
  logic [DW-1:0]               dp_r;
  logic [DELAY_DEPTH-1:0]      dvld_r;
  logic                        out_valid_r;

  logic [PW+1:0] dly_a [DELAY_DEPTH];
  logic [PW:0]   dly_b [DELAY_DEPTH];
  logic [PW+1:0] dq_a_r;
  logic [PW:0]   dq_b_r;
  logic          dq_v_r;

  logic [PW+1:0] cur_a_r;
  logic [PW:0]   cur_b_r;
  logic [PW:0]   base_out_r, conv_out_r, span_b_out_r;
  logic [PW+1:0] span_a_out_r;

  logic                        accept;
  logic [imwm_pkg::BARS_W-1:0] bar_idx;
  logic [AW-1:0]               ptr_base, ptr_nxt;
  logic [imwm_pkg::BARS_W-1:0] bars_nxt;
  logic [XW-1:0]               ceil_ext;
  logic [PW-1:0]               ceiling;
  imwm_pkg::scan_req_t         req;
  logic                        scan_done;
  logic [PW:0]                 conv_sum, base_sum, long_sum;
  logic [31:0]                 sh32;
  logic [DW-1:0]               sh;
  logic [DW:0]                 rd_sum;
  logic [DW-1:0]               rd_addr;
  logic                        out_load;

  assign accept   = in_chan.valid && in_chan.ready;
  assign bar_idx  = in_chan.series_start ? '0 : bars_r;
  assign ptr_base = in_chan.series_start ? '0 : ptr_r;
  assign ptr_nxt  = (bar_idx == '0) ? ptr_base :
                    ((ptr_base == AW'(HISTORY_DEPTH - 1)) ? '0 : ptr_base + 1'b1);
  assign bars_nxt = (bar_idx == imwm_pkg::BARS_MAX) ? bar_idx : bar_idx + 1'b1;

  assign ceil_ext = {{PW{1'b0}}, ceil_r};
  assign ceiling  = ceil_ext[PW-1:0];

  assign req.start      = accept && (bar_idx != '0);
  assign req.bars       = bar_idx;
  assign req.win_short  = win_s_r;
  assign req.win_medium = win_m_r;
  assign req.win_long   = win_l_r;

  imwm_scan #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .PRICE_WIDTH   (PRICE_WIDTH)
  ) u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (req),
    .ptr      (ptr_nxt),
    .ceiling  (ceiling),
    .wr_en    (accept),
    .wr_addr  (ptr_nxt),
    .wr_high  (in_chan.bar_high),
    .wr_low   (in_chan.bar_low),
    .done     (scan_done),
    .conv_sum (conv_sum),
    .base_sum (base_sum),
    .long_sum (long_sum)
  );

  // span delay read position, shift clamped to one below the delay depth
  assign sh32    = 32'(shift_r);
  assign sh      = (sh32 > 32'(DELAY_DEPTH - 1)) ? DW'(DELAY_DEPTH - 1) : sh32[DW-1:0];
  assign rd_sum  = {1'b0, dp_r} + (DW + 1)'(DELAY_DEPTH) - {1'b0, sh};
  assign rd_addr = (dp_r >= sh) ? (dp_r - sh) : rd_sum[DW-1:0];

  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_chan.ready);

  assign in_chan.ready  = (state_r == S_IDLE);
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      win_s_r     <= imwm_pkg::SHORT_WINDOW_RST;
      win_m_r     <= imwm_pkg::MEDIUM_WINDOW_RST;
      win_l_r     <= imwm_pkg::LONG_WINDOW_RST;
      shift_r     <= imwm_pkg::SPAN_SHIFT_RST;
      ceil_r      <= imwm_pkg::LOW_CEILING_RST;
      bars_r      <= '0;
      ptr_r       <= '0;
      dp_r        <= '0;
      dvld_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_chan.valid) begin
        case (cfg_chan.reg_index)
          imwm_pkg::CFG_SHORT_WINDOW:  win_s_r <= cfg_chan.wr_data[imwm_pkg::WIN_W-1:0];
          imwm_pkg::CFG_MEDIUM_WINDOW: win_m_r <= cfg_chan.wr_data[imwm_pkg::WIN_W-1:0];
          imwm_pkg::CFG_LONG_WINDOW:   win_l_r <= cfg_chan.wr_data[imwm_pkg::WIN_W-1:0];
          imwm_pkg::CFG_SPAN_SHIFT:    shift_r <= cfg_chan.wr_data[imwm_pkg::SHIFT_W-1:0];
          imwm_pkg::CFG_LOW_CEILING:   ceil_r  <= cfg_chan.wr_data;
          default: ;
        endcase
      end

      if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (accept) begin
            bars_r <= bars_nxt;
            ptr_r  <= ptr_nxt;
            if (in_chan.series_start) begin
              dp_r   <= '0;
              dvld_r <= '0;
            end
            if (bar_idx != '0) begin
              state_r <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (scan_done) begin
            state_r <= S_RD;
          end
        end
        S_RD: begin
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            out_valid_r  <= 1'b1;
            dvld_r[dp_r] <= 1'b1;
            dp_r         <= (dp_r == DW'(DELAY_DEPTH - 1)) ? '0 : dp_r + 1'b1;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_SCAN && scan_done) begin
      cur_a_r <= {1'b0, base_sum} + {1'b0, conv_sum};
      cur_b_r <= long_sum;
    end
    if (state_r == S_RD) begin
      dq_a_r <= dly_a[rd_addr];
      dq_b_r <= dly_b[rd_addr];
      dq_v_r <= dvld_r[rd_addr];
    end
    if (out_load) begin
      dly_a[dp_r]  <= cur_a_r;
      dly_b[dp_r]  <= cur_b_r;
      base_out_r   <= base_sum;
      conv_out_r   <= conv_sum;
      // no shift: current spans pass straight through
      if (sh == '0) begin
        span_a_out_r <= cur_a_r;
        span_b_out_r <= cur_b_r;
      end else begin
        span_a_out_r <= dq_v_r ? dq_a_r : '0;
        span_b_out_r <= dq_v_r ? dq_b_r : '0;
      end
    end
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.base_line       = base_out_r;
  assign out_chan.conversion_line = conv_out_r;
  assign out_chan.leading_span_a  = span_a_out_r;
  assign out_chan.leading_span_b  = span_b_out_r;

endmodule

`default_nettype wire
